FILE: rtl/mexp_pkg.sv
package mexp_pkg;

  // operand width used by the datapath; ports stay at the field width
  localparam int OPERAND_BITS = 63;
  localparam int FIELD_W      = 63;
  localparam int CNT_W        = $clog2(OPERAND_BITS);

  typedef logic [OPERAND_BITS-1:0] res_t;
  typedef logic [FIELD_W-1:0]      field_t;

  typedef enum logic [1:0] {
    OPC_MUL  = 2'd0,
    OPC_POW  = 2'd1,
    OPC_POWF = 2'd2,
    OPC_RSV  = 2'd3
  } opcode_t;

  // request to the serial modular multiplier: x * y mod modv, x < modv
  typedef struct packed {
    logic start;
    res_t x;
    res_t y;
    res_t modv;
  } mm_req_t;

endpackage

FILE: rtl/mexp_modmul.sv
// Bit-serial modular multiply, multiplier LSB first, one bit per cycle.
module mexp_modmul (
  input  logic             clk,
  input  logic             rst_n,
  input  mexp_pkg::mm_req_t req,
  output logic             done,
  output mexp_pkg::res_t   prod
);

  logic                       busy_r, busy_nxt;
  logic                       done_r, done_nxt;
  logic [mexp_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  mexp_pkg::res_t             acc_r, acc_nxt;
  mexp_pkg::res_t             x_r, x_nxt;
  mexp_pkg::res_t             y_r, y_nxt;
  mexp_pkg::res_t             m_r, m_nxt;

  logic [mexp_pkg::OPERAND_BITS:0] sum_acc, sum_x, m_ext;
  mexp_pkg::res_t                  acc_step, x_step;

  // both operands below m, so one conditional subtract reduces each sum
  always_comb begin
    m_ext   = {1'b0, m_r};
    sum_acc = {1'b0, acc_r} + {1'b0, x_r};
    sum_x   = {1'b0, x_r} + {1'b0, x_r};
    if (sum_acc >= m_ext) begin
      sum_acc = sum_acc - m_ext;
    end
    if (sum_x >= m_ext) begin
      sum_x = sum_x - m_ext;
    end
    acc_step = y_r[0] ? sum_acc[mexp_pkg::OPERAND_BITS-1:0] : acc_r;
    x_step   = sum_x[mexp_pkg::OPERAND_BITS-1:0];
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    acc_nxt  = acc_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    m_nxt    = m_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = mexp_pkg::CNT_W'(mexp_pkg::OPERAND_BITS - 1);
      acc_nxt  = '0;
      x_nxt    = req.x;
      y_nxt    = req.y;
      m_nxt    = req.modv;
    end else if (busy_r) begin
      acc_nxt = acc_step;
      x_nxt   = x_step;
      y_nxt   = y_r >> 1;
      cnt_nxt = cnt_r - mexp_pkg::CNT_W'(1);
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    acc_r <= acc_nxt;
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    m_r   <= m_nxt;
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule

FILE: rtl/modular_exponentiation_unit.sv
// Channel  Dir  Ports
// in       in   in_valid in_stall in_opcode in_base_value in_second_operand in_modulus_value
// out      out  out_valid out_stall out_result_value out_error_flag
//
// One request at a time; in_stall is high while one is in progress. Each product is one
// pass of the bit-serial multiplier, which takes OPERAND_BITS steps.
// Multiply does a base reduction, then the product. Power does the base reduction, then
// up to two products (multiply, then square) per exponent bit, of up to 63; Fermat power
// adds one reduction of the exponent mod (m-1). Invalid requests go straight to S_DONE.
// Reset synchronous, active low. A stalled result holds in the output register while the
// next request runs; that one waits in S_DONE only if the register is still full.
module modular_exponentiation_unit (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [1:0]                 in_opcode,
  input  logic [mexp_pkg::FIELD_W-1:0] in_base_value,
  input  logic [mexp_pkg::FIELD_W-1:0] in_second_operand,
  input  logic [mexp_pkg::FIELD_W-1:0] in_modulus_value,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [mexp_pkg::FIELD_W-1:0] out_result_value,
  output logic                       out_error_flag
);

  // one-hot sequencer states
  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_REDA = 8'b0000_0010,  // base mod m
    S_REDE = 8'b0000_0100,  // exponent mod (m-1)
    S_MUL  = 8'b0000_1000,  // plain product
    S_STEP = 8'b0001_0000,  // pick next exponent action
    S_PMUL = 8'b0010_0000,  // acc * x
    S_PSQR = 8'b0100_0000,  // x * x
    S_DONE = 8'b1000_0000   // result ready for the output register
  } state_t;

  state_t             state_r, state_nxt;
  mexp_pkg::opcode_t  opc_r, opc_nxt;
  mexp_pkg::res_t     m_r, m_nxt;
  mexp_pkg::res_t     e_r, e_nxt;     // exponent / multiplier
  mexp_pkg::res_t     x_r, x_nxt;     // running base power
  mexp_pkg::res_t     acc_r, acc_nxt;
  mexp_pkg::res_t     res_r, res_nxt;
  logic               err_r, err_nxt;
  mexp_pkg::mm_req_t  req_r, req_nxt;

  logic                 out_valid_r, out_valid_nxt;
  mexp_pkg::res_t       out_res_r, out_res_nxt;
  logic                 out_err_r, out_err_nxt;

  logic                 mm_done;
  mexp_pkg::res_t       mm_prod;

  mexp_pkg::opcode_t    in_opc;
  mexp_pkg::res_t       in_a, in_b, in_m;
  mexp_pkg::res_t       one_in, one_m, one_m1;
  logic                 in_bad;
  logic                 out_free;

  mexp_modmul u_modmul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req_r),
    .done  (mm_done),
    .prod  (mm_prod)
  );

  always_comb begin
    in_opc = mexp_pkg::opcode_t'(in_opcode);
    in_a   = in_base_value[mexp_pkg::OPERAND_BITS-1:0];
    in_b   = in_second_operand[mexp_pkg::OPERAND_BITS-1:0];
    in_m   = in_modulus_value[mexp_pkg::OPERAND_BITS-1:0];
    // 1 mod m; reducing x by multiplying 1 with x as the serial operand
    one_in = mexp_pkg::res_t'(in_m != mexp_pkg::res_t'(1));
    one_m  = mexp_pkg::res_t'(m_r != mexp_pkg::res_t'(1));
    one_m1 = mexp_pkg::res_t'(m_r != mexp_pkg::res_t'(2));
    in_bad = (in_m == '0) || (in_opc == mexp_pkg::OPC_RSV) ||
             ((in_opc == mexp_pkg::OPC_POWF) && (in_m == mexp_pkg::res_t'(1)));
    out_free = !out_valid_r || !out_stall;
  end

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt     = state_r;
    opc_nxt       = opc_r;
    m_nxt         = m_r;
    e_nxt         = e_r;
    x_nxt         = x_r;
    acc_nxt       = acc_r;
    res_nxt       = res_r;
    err_nxt       = err_r;
    req_nxt       = req_r;
    req_nxt.start = 1'b0;
    out_valid_nxt = out_valid_r && out_stall;
    out_res_nxt   = out_res_r;
    out_err_nxt   = out_err_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          opc_nxt = in_opc;
          m_nxt   = in_m;
          e_nxt   = in_b;
          if (in_bad) begin
            res_nxt   = '0;
            err_nxt   = 1'b1;
            state_nxt = S_DONE;
          end else begin
            err_nxt   = 1'b0;
            req_nxt   = '{start: 1'b1, x: one_in, y: in_a, modv: in_m};
            state_nxt = S_REDA;
          end
        end
      end
      S_REDA: begin
        if (mm_done) begin
          x_nxt = mm_prod;
          unique case (opc_r)
            mexp_pkg::OPC_MUL: begin
              req_nxt   = '{start: 1'b1, x: mm_prod, y: e_r, modv: m_r};
              state_nxt = S_MUL;
            end
            mexp_pkg::OPC_POWF: begin
              req_nxt   = '{start: 1'b1, x: one_m1, y: e_r,
                            modv: m_r - mexp_pkg::res_t'(1)};
              state_nxt = S_REDE;
            end
            default: begin
              acc_nxt   = one_m;
              state_nxt = S_STEP;
            end
          endcase
        end
      end
      S_MUL: begin
        if (mm_done) begin
          res_nxt   = mm_prod;
          state_nxt = S_DONE;
        end
      end
      S_REDE: begin
        if (mm_done) begin
          e_nxt     = mm_prod;
          acc_nxt   = one_m;
          state_nxt = S_STEP;
        end
      end
      S_STEP: begin
        if (e_r == '0) begin
          res_nxt   = acc_r;
          state_nxt = S_DONE;
        end else if (e_r[0]) begin
          req_nxt   = '{start: 1'b1, x: acc_r, y: x_r, modv: m_r};
          state_nxt = S_PMUL;
        end else begin
          req_nxt   = '{start: 1'b1, x: x_r, y: x_r, modv: m_r};
          state_nxt = S_PSQR;
        end
      end
      S_PMUL: begin
        if (mm_done) begin
          acc_nxt   = mm_prod;
          req_nxt   = '{start: 1'b1, x: x_r, y: x_r, modv: m_r};
          state_nxt = S_PSQR;
        end
      end
      S_PSQR: begin
        if (mm_done) begin
          x_nxt     = mm_prod;
          e_nxt     = e_r >> 1;
          state_nxt = S_STEP;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_res_nxt   = res_r;
          out_err_nxt   = err_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      req_r         <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      req_r         <= req_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    opc_r      <= opc_nxt;
    m_r        <= m_nxt;
    e_r        <= e_nxt;
    x_r        <= x_nxt;
    acc_r      <= acc_nxt;
    res_r      <= res_nxt;
    err_r      <= err_nxt;
    out_res_r  <= out_res_nxt;
    out_err_r  <= out_err_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_result_value = mexp_pkg::FIELD_W'(out_res_r);
  assign out_error_flag   = out_err_r;

`ifndef SYNTHESIS
  // an error result always carries a zero residue
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_error_flag |-> out_result_value == '0)
    else $error("error result with nonzero residue");

  // multiplier only finishes while the sequencer waits on it
  a_mm_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    mm_done |-> (state_r == S_REDA || state_r == S_REDE || state_r == S_MUL ||
                 state_r == S_PMUL || state_r == S_PSQR))
    else $error("multiplier done outside a wait state");

  // an accepted request leaves the idle state
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> state_r != S_IDLE)
    else $error("request accepted without starting");
`endif

endmodule
